/* sv/tts_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tts_pkg
// Shared widths, types and the arctangent table for the steering converter.
// ----------------------------------------------------------------------------
package tts_pkg;

  // field widths
  localparam int SpeedW     = 16;
  localparam int YawW       = 16;
  localparam int AngleW     = 12;
  localparam int WheelBaseW = 12;
  localparam int SteerLimW  = 11;
  localparam int SpeedLimW  = 15;

  // cordic datapath widths: |x|,|y| stay below 2^45 over all stages
  localparam int CordicW = 48;
  localparam int AngleZW = 19;
  localparam int TableW  = 17;
  localparam int FracW   = 16;
  localparam int TableLen = 24;

  // default stage count
  localparam int AngleStagesDef = 16;

  // register indexes
  localparam logic [1:0] RegWheelBase = 2'd0;
  localparam logic [1:0] RegSteerLim  = 2'd1;
  localparam logic [1:0] RegSpeedLim  = 2'd2;

  // register reset values
  localparam logic [WheelBaseW-1:0] WheelBaseRst = 12'd320;
  localparam logic [SteerLimW-1:0]  SteerLimRst  = 11'd450;
  localparam logic [SpeedLimW-1:0]  SpeedLimRst  = 15'd2000;

  // side data that rides along with each request
  typedef struct packed {
    logic signed [SpeedW-1:0] speed;
    logic                     slow;
  } side_t;

  // atan(2^-i) in units of 2^-16 rad, rounded
  function automatic logic [TableW-1:0] atan_entry(input int i);
    logic [TableW-1:0] val;
    case (i)
      0:  val = 17'd51472;
      1:  val = 17'd30385;
      2:  val = 17'd16055;
      3:  val = 17'd8150;
      4:  val = 17'd4091;
      5:  val = 17'd2047;
      6:  val = 17'd1024;
      7:  val = 17'd512;
      8:  val = 17'd256;
      9:  val = 17'd128;
      10: val = 17'd64;
      11: val = 17'd32;
      12: val = 17'd16;
      13: val = 17'd8;
      14: val = 17'd4;
      15: val = 17'd2;
      16: val = 17'd1;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

/* sv/tts_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tts_front
// Speed clamp, sign fold and the two operand products for the arctangent.
// ----------------------------------------------------------------------------
module tts_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [15:0]            cmd_speed,
  input  logic signed [15:0]            cmd_yaw_rate,
  input  logic [11:0]                   wheel_base_mm,
  input  logic [14:0]                   speed_limit_mm_s,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [tts_pkg::CordicW-1:0] out_x,
  output logic signed [tts_pkg::CordicW-1:0] out_y,
  output tts_pkg::side_t                out_side
);
  import tts_pkg::*;

  // stage one registers
  logic                     v1;
  logic [SpeedLimW-1:0]     mag1;
  logic signed [YawW:0]     yaw1;
  side_t                    side1;
  // stage two registers
  logic                     v2;
  logic [24:0]              xprod2;
  logic signed [28:0]       yprod2;
  side_t                    side2;

  logic rdy1, rdy2;
  logic signed [SpeedW:0]   spd_ext, lim_pos, lim_neg;
  logic signed [SpeedW-1:0] spd_clamped;
  logic [SpeedLimW-1:0]     spd_mag;
  logic signed [YawW:0]     yaw_ext;

  assign rdy2     = !v2 || out_ready;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  // clamp speed to the limit and take its magnitude
  always_comb begin
    spd_ext = {cmd_speed[SpeedW-1], cmd_speed};
    lim_pos = $signed({2'b00, speed_limit_mm_s});
    lim_neg = -lim_pos;
    if (spd_ext > lim_pos) begin
      spd_clamped = lim_pos[SpeedW-1:0];
    end else if (spd_ext < lim_neg) begin
      spd_clamped = lim_neg[SpeedW-1:0];
    end else begin
      spd_clamped = cmd_speed;
    end
    if (spd_clamped[SpeedW-1]) begin
      spd_mag = SpeedLimW'(-spd_clamped);
    end else begin
      spd_mag = spd_clamped[SpeedLimW-1:0];
    end
    yaw_ext = {cmd_yaw_rate[YawW-1], cmd_yaw_rate};
  end

  // stage one: clamp and sign fold of the yaw rate
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= in_valid;
    end
    if (rdy1) begin
      mag1        <= spd_mag;
      yaw1        <= spd_clamped[SpeedW-1] ? -yaw_ext : yaw_ext;
      side1.speed <= spd_clamped;
      side1.slow  <= (spd_mag <= SpeedLimW'(1));
    end
  end

  // stage two: the two products
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
    if (rdy2) begin
      xprod2 <= 25'(mag1 * 25'd1000);
      yprod2 <= $signed({17'd0, wheel_base_mm}) * $signed({{12{yaw1[YawW]}}, yaw1});
      side2  <= side1;
    end
  end

  assign out_valid = v2;
  assign out_x     = $signed({{(CordicW-25-FracW){1'b0}}, xprod2, {FracW{1'b0}}});
  assign out_y     = $signed({{(CordicW-29-FracW){yprod2[28]}}, yprod2, {FracW{1'b0}}});
  assign out_side  = side2;

endmodule

/* sv/tts_cordic.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tts_cordic
// Vectoring cordic, one registered micro-rotation per stage.
// ----------------------------------------------------------------------------
module tts_cordic #(
  parameter int ANGLE_STAGES = tts_pkg::AngleStagesDef
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [tts_pkg::CordicW-1:0] in_x,
  input  logic signed [tts_pkg::CordicW-1:0] in_y,
  input  tts_pkg::side_t                     in_side,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [tts_pkg::AngleZW-1:0] out_z,
  output tts_pkg::side_t                     out_side
);
  import tts_pkg::*;

  logic                      vld  [0:ANGLE_STAGES];
  logic                      rdy  [0:ANGLE_STAGES];
  logic signed [CordicW-1:0] cx   [0:ANGLE_STAGES];
  logic signed [CordicW-1:0] cy   [0:ANGLE_STAGES];
  logic signed [AngleZW-1:0] cz   [0:ANGLE_STAGES];
  side_t                     side [0:ANGLE_STAGES];

  assign vld[0]  = in_valid;
  assign cx[0]   = in_x;
  assign cy[0]   = in_y;
  assign cz[0]   = '0;
  assign side[0] = in_side;
  assign in_ready = rdy[0];
  assign rdy[ANGLE_STAGES] = out_ready;

  for (genvar k = 0; k < ANGLE_STAGES; k++) begin : g_stage
    localparam logic [AngleZW-1:0] Step =
      AngleZW'(atan_entry(k));
    logic signed [CordicW-1:0] dx, dy;

    // floor shifts of the previous vector
    assign dx = cy[k] >>> k;
    assign dy = cx[k] >>> k;
    assign rdy[k] = !vld[k+1] || rdy[k+1];

    // rotate towards the x axis
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (rdy[k]) begin
        vld[k+1] <= vld[k];
      end
      if (rdy[k]) begin
        side[k+1] <= side[k];
        if (!cy[k][CordicW-1]) begin
          cx[k+1] <= cx[k] + dx;
          cy[k+1] <= cy[k] - dy;
          cz[k+1] <= cz[k] + $signed(Step);
        end else begin
          cx[k+1] <= cx[k] - dx;
          cy[k+1] <= cy[k] + dy;
          cz[k+1] <= cz[k] - $signed(Step);
        end
      end
    end
  end

  assign out_valid = vld[ANGLE_STAGES];
  assign out_z     = cz[ANGLE_STAGES];
  assign out_side  = side[ANGLE_STAGES];

endmodule

/* sv/tts_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tts_back
// Scales the angle to milliradians, applies the limit and holds the result.
// ----------------------------------------------------------------------------
module tts_back (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [tts_pkg::AngleZW-1:0] in_z,
  input  tts_pkg::side_t                     in_side,
  input  logic [10:0]                        steer_limit_mrad,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [15:0]                 out_speed,
  output logic signed [11:0]                 steer_angle
);
  import tts_pkg::*;

  localparam int ProdW = 28;

  logic                   v1, v2;
  logic                   neg1;
  logic [AngleW-1:0]      q1;
  side_t                  side1;
  logic signed [SpeedW-1:0] speed2;
  logic signed [AngleW-1:0] angle2;

  logic rdy1, rdy2;
  logic [AngleZW-2:0]     zmag;
  logic [ProdW-1:0]       prod;
  logic [AngleW-1:0]      lim, sel;

  assign rdy2     = !v2 || out_ready;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  // magnitude times 1000 with half-up rounding
  always_comb begin
    zmag = in_z[AngleZW-1] ? (AngleZW-1)'(-in_z) : in_z[AngleZW-2:0];
    prod = ProdW'(zmag * ProdW'(1000)) + ProdW'(32768);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= in_valid;
    end
    if (rdy1) begin
      neg1  <= in_z[AngleZW-1];
      q1    <= prod[FracW +: AngleW];
      side1 <= in_side;
    end
  end

  // limit magnitude and zero at low speed; the sign is restored in the output register
  always_comb begin
    lim = {1'b0, steer_limit_mrad};
    if (side1.slow) begin
      sel = '0;
    end else if (q1 > lim) begin
      sel = lim;
    end else begin
      sel = q1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
    if (rdy2) begin
      speed2 <= side1.speed;
      angle2 <= neg1 ? -$signed(sel) : $signed(sel);
    end
  end

  assign out_valid   = v2;
  assign out_speed   = speed2;
  assign steer_angle = angle2;

endmodule

/* sv/twist_to_steering_angle.sv */
`timescale 1ns / 1ps
// path: a request passes the front registers, the cordic stages and the back registers in that order
// throughput: one request per cycle while m_tready is not held low, set by the fully pipelined cordic stages
// every stage has its own valid bit and a ready chain, so bubbles close up
// reset: synchronous, clears all valid bits and loads the register defaults
//   (wheel base 320 mm, steering limit 450 mrad, speed limit 2000 mm/s)
// ----------------------------------------------------------------------------
// twist_to_steering_angle
// Bicycle-model conversion of speed and yaw rate into a steering angle.
// ----------------------------------------------------------------------------
module twist_to_steering_angle #(
  parameter int ANGLE_STAGES = tts_pkg::AngleStagesDef
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [14:0] cfg_data,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // cmd_speed [15:0], cmd_yaw_rate [31:16]
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // out_speed [15:0], steer_angle [27:16], zero [31:28]
);
  import tts_pkg::*;

  logic [WheelBaseW-1:0] wheel_base_mm;
  logic [SteerLimW-1:0]  steer_limit_mrad;
  logic [SpeedLimW-1:0]  speed_limit_mm_s;

  logic                      f_valid, f_ready;
  logic signed [CordicW-1:0] f_x, f_y;
  side_t                     f_side;
  logic                      c_valid, c_ready;
  logic signed [AngleZW-1:0] c_z;
  side_t                     c_side;
  logic signed [SpeedW-1:0]  out_speed;
  logic signed [AngleW-1:0]  steer_angle;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wheel_base_mm    <= WheelBaseRst;
      steer_limit_mrad <= SteerLimRst;
      speed_limit_mm_s <= SpeedLimRst;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        RegWheelBase: wheel_base_mm    <= cfg_data[WheelBaseW-1:0];
        RegSteerLim:  steer_limit_mrad <= cfg_data[SteerLimW-1:0];
        RegSpeedLim:  speed_limit_mm_s <= cfg_data[SpeedLimW-1:0];
        default: ;
      endcase
    end
  end

  tts_front u_front (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (s_tvalid),
    .in_ready         (s_tready),
    .cmd_speed        ($signed(s_tdata[15:0])),
    .cmd_yaw_rate     ($signed(s_tdata[31:16])),
    .wheel_base_mm    (wheel_base_mm),
    .speed_limit_mm_s (speed_limit_mm_s),
    .out_valid        (f_valid),
    .out_ready        (f_ready),
    .out_x            (f_x),
    .out_y            (f_y),
    .out_side         (f_side)
  );

  tts_cordic #(
    .ANGLE_STAGES (ANGLE_STAGES)
  ) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_x      (f_x),
    .in_y      (f_y),
    .in_side   (f_side),
    .out_valid (c_valid),
    .out_ready (c_ready),
    .out_z     (c_z),
    .out_side  (c_side)
  );

  tts_back u_back (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (c_valid),
    .in_ready         (c_ready),
    .in_z             (c_z),
    .in_side          (c_side),
    .steer_limit_mrad (steer_limit_mrad),
    .out_valid        (m_tvalid),
    .out_ready        (m_tready),
    .out_speed        (out_speed),
    .steer_angle      (steer_angle)
  );

  assign m_tdata = {4'b0000, steer_angle, out_speed};

endmodule

/* sv/tts_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tts_checker
// Port-level checks on the steering converter, bound to the top level.
// ----------------------------------------------------------------------------
module tts_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // reset empties the pipeline
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // near standstill the angle is zero
  a_slow: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[15:0] == 16'h0000 || m_tdata[15:0] == 16'h0001 ||
                 m_tdata[15:0] == 16'hFFFF) |-> m_tdata[27:16] == 12'h000)
    else $error("nonzero angle at low speed");

  // clamped speed never reaches the most negative code, pad bits stay zero
  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[15:0] != 16'h8000 && m_tdata[31:28] == 4'h0)
    else $error("speed out of range or pad bits set");

endmodule

bind twist_to_steering_angle tts_checker u_tts_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
